// ----- hw/rtl/rse_pkg.sv -----
// Package for the radix sort engine: sizes, radix and digit helpers.
// No dependencies.
package rse_pkg;
    localparam int MaxItems = 64;
    localparam int Radix = 10;
    localparam int AddrW = $clog2(MaxItems);
    localparam int CntW = $clog2(MaxItems + 1);
    localparam int DigW = $clog2(Radix);
    localparam int NumPasses = 10;
    localparam int PassW = $clog2(NumPasses + 1);

    typedef struct packed {
        logic [31:0] value;
        logic        last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] sorted_value;
        logic        end_of_batch;
        logic        overflowed;
    } t_out_beat;

    // One scratch entry: the rebased value, the quotient left for the later
    // passes and the digit that the current pass sorts on.
    typedef struct packed {
        logic [31:0]     diff;
        logic [31:0]     quo;
        logic [DigW-1:0] dig;
    } t_scr_entry;

    // Quotient by ten through a reciprocal multiply, exact for every 32-bit input.
    function automatic logic [31:0] div10(input logic [31:0] x);
        logic [63:0] p;
        p = {32'd0, x} * 64'h0000_0000_CCCC_CCCD;
        return {3'd0, p[63:35]};
    endfunction

    // Number of decimal digits of a 32-bit value, zero for zero.
    function automatic logic [PassW-1:0] num_digits(input logic [31:0] x);
        logic [PassW-1:0] n;
        logic [35:0]      w;
        n = '0;
        w = 36'd1;
        for (int k = 0; k < NumPasses; k++) begin
            if ({4'd0, x} >= w) n = PassW'(k + 1);
            w = w * 36'(Radix);
        end
        return n;
    endfunction
endpackage

// ----- hw/rtl/rse_if.sv -----
// Valid/ready channel interface carrying one beat of payload.
// Depends on nothing; the payload type is a parameter.
interface rse_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/radix_sort_engine.sv -----
// Radix sort engine top level.
// Depends on rse_pkg and rse_if.
//
// Values load at one beat per cycle into a 64-entry item memory while the
// minimum and maximum are tracked. A beat marked last starts the sort: the
// batch is rebased by the minimum and its lowest decimal digit split off,
// then one stable base-10 counting pass runs per decimal digit of the
// largest difference. Each pass has a start step, a count sweep, a
// nine-step prefix sum, a backward scatter and a copy back that also splits
// off the next digit. Output then starts, primes a read and sends n beats
// through the output register, one per cycle while the receiver keeps up.
// Input is held off from the last beat until the last output beat has
// entered the output register.
module radix_sort_engine (
    input  logic i_clk,
    input  logic i_rst_n,
    rse_if.sink   i_in,
    rse_if.source o_out
);
    typedef enum logic [3:0] {
        S_LOAD, S_REBASE, S_CNT, S_PFX, S_SUM, S_SCAT, S_COPY, S_EMIT
    } t_state;

    t_state r_state;
    logic [rse_pkg::CntW-1:0] r_n, r_i;
    logic [31:0] r_min, r_max;
    logic r_ovf;
    logic [rse_pkg::PassW-1:0] r_pass, r_npass;
    logic [rse_pkg::DigW-1:0] r_k;
    logic [rse_pkg::CntW-1:0] r_cnt [rse_pkg::Radix];
    logic [31:0] r_items [rse_pkg::MaxItems];
    rse_pkg::t_scr_entry r_scr [rse_pkg::MaxItems];
    rse_pkg::t_scr_entry r_tmp [rse_pkg::MaxItems];
    logic [31:0] r_item_rd;
    rse_pkg::t_scr_entry r_rd;
    logic r_rd_v;
    logic r_ov_v;
    rse_pkg::t_out_beat r_ob;

    logic in_fire;
    logic emit_go;
    logic out_load;
    logic [31:0] v;
    logic [31:0] item_diff;
    logic [31:0] q10;
    logic [rse_pkg::DigW-1:0] r10;
    logic [rse_pkg::DigW-1:0] dg;
    logic [rse_pkg::CntW-1:0] slot;

    assign in_fire = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_LOAD);
    assign v = i_in.data.value;
    assign o_out.valid = r_ov_v;
    assign o_out.data = r_ob;
    assign emit_go = !r_ov_v || o_out.ready;
    assign out_load = (r_state == S_EMIT) && emit_go && r_rd_v;
    assign item_diff = r_item_rd - r_min;
    assign dg = r_rd.dig;
    assign slot = r_cnt[dg] - 1'b1;

    // The next quotient and digit, split off while copying back.
    assign q10 = rse_pkg::div10(r_rd.quo);
    assign r10 = rse_pkg::DigW'(r_rd.quo - ((q10 << 3) + (q10 << 1)));

    // Memories: synchronous read, one write per cycle each.
    always_ff @(posedge i_clk) begin
        if (in_fire && r_n < rse_pkg::CntW'(rse_pkg::MaxItems))
            r_items[r_n[rse_pkg::AddrW-1:0]] <= v;
        if (r_state == S_REBASE && r_rd_v)
            r_tmp[r_i[rse_pkg::AddrW-1:0] - 1'b1] <= '{diff: item_diff, quo: item_diff,
                                                       dig: '0};
        if (r_state == S_SCAT && r_rd_v)
            r_tmp[slot[rse_pkg::AddrW-1:0]] <= r_rd;
        if (r_state == S_COPY && r_rd_v)
            r_scr[r_i[rse_pkg::AddrW-1:0] - 1'b1] <= '{diff: r_rd.diff, quo: q10, dig: r10};
        r_item_rd <= r_items[r_i[rse_pkg::AddrW-1:0]];
        unique case (r_state)
            S_COPY:   r_rd <= r_tmp[r_i[rse_pkg::AddrW-1:0]];
            S_SCAT:   r_rd <= r_scr[r_i[rse_pkg::AddrW-1:0] - 1'b1];
            S_EMIT: begin
                // Hold the pending entry while the output register is stuck.
                if (emit_go) r_rd <= r_scr[r_i[rse_pkg::AddrW-1:0]];
            end
            default:  r_rd <= r_scr[r_i[rse_pkg::AddrW-1:0]];
        endcase
    end

    // Sequencer, counters and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_n <= '0;
            r_ovf <= 1'b0;
            r_rd_v <= 1'b0;
            r_ov_v <= 1'b0;
            r_i <= '0;
        end else begin
            if (out_load) r_ov_v <= 1'b1;
            else if (o_out.valid && o_out.ready) r_ov_v <= 1'b0;
            unique case (r_state)
                S_LOAD: begin
                    if (in_fire) begin
                        if (r_n < rse_pkg::CntW'(rse_pkg::MaxItems)) begin
                            if (r_n == '0 || $signed(v) < $signed(r_min)) r_min <= v;
                            if (r_n == '0 || $signed(v) > $signed(r_max)) r_max <= v;
                            r_n <= r_n + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_in.data.last) begin
                            r_state <= S_REBASE;
                            r_i <= '0;
                            r_rd_v <= 1'b0;
                        end
                    end
                end
                S_REBASE: begin
                    if (r_i == r_n) begin
                        r_npass <= rse_pkg::num_digits(r_max - r_min);
                        // One below zero, so the copy that splits off the
                        // first digit lands on pass zero.
                        r_pass <= '1;
                        r_state <= S_COPY;
                        r_i <= '0;
                        r_rd_v <= 1'b0;
                    end else begin
                        r_rd_v <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_PFX: begin
                    // Entered once per pass start; start counting or emit.
                    if (r_pass == r_npass) begin
                        r_state <= S_EMIT;
                        r_i <= '0;
                        r_rd_v <= 1'b0;
                    end else begin
                        r_state <= S_CNT;
                        r_i <= '0;
                        r_rd_v <= 1'b0;
                        for (int k = 0; k < rse_pkg::Radix; k++) r_cnt[k] <= '0;
                    end
                end
                S_CNT: begin
                    if (r_rd_v) r_cnt[dg] <= r_cnt[dg] + 1'b1;
                    if (r_i == r_n) begin
                        r_state <= S_SUM;
                        r_k <= rse_pkg::DigW'(1);
                        r_rd_v <= 1'b0;
                    end else begin
                        r_rd_v <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_SUM: begin
                    // Running prefix sum, one counter per cycle.
                    r_cnt[r_k] <= r_cnt[r_k] + r_cnt[r_k - 1'b1];
                    if (r_k == rse_pkg::DigW'(rse_pkg::Radix - 1)) begin
                        r_state <= S_SCAT;
                        r_i <= r_n;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SCAT: begin
                    if (r_rd_v) r_cnt[dg] <= slot;
                    if (r_i != '0) begin
                        r_rd_v <= 1'b1;
                        r_i <= r_i - 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                        if (!r_rd_v) r_state <= S_COPY;
                    end
                end
                S_COPY: begin
                    if (r_i == r_n) begin
                        r_pass <= r_pass + 1'b1;
                        r_state <= S_PFX;
                        r_rd_v <= 1'b0;
                    end else begin
                        r_rd_v <= 1'b1;
                        r_i <= r_i + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (r_rd_v) begin
                            r_ob.sorted_value <= r_rd.diff + r_min;
                            r_ob.end_of_batch <= (r_i == r_n);
                            r_ob.overflowed <= r_ovf;
                        end
                        if (r_i < r_n) begin
                            r_rd_v <= 1'b1;
                            r_i <= r_i + 1'b1;
                        end else begin
                            r_rd_v <= 1'b0;
                            if (r_rd_v) begin
                                r_state <= S_LOAD;
                                r_n <= '0;
                                r_ovf <= 1'b0;
                            end
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    // The first digit counter never exceeds the batch size in a pass.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT || r_state == S_SUM || r_state == S_SCAT) |-> r_cnt[0] <= r_n)
        else $error("digit count above batch size");
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_LOAD) |-> !i_in.ready) else $error("input taken while sorting");
    a_batch_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= rse_pkg::CntW'(rse_pkg::MaxItems)) else $error("batch count overrun");
endmodule
